### sv/qpac_pkg.sv
// ----------------------------------------------------------------------------
// qpac_pkg
// Shared types, register indexes, operation codes and cipher helper functions
// for the pointer authentication code unit.
// ----------------------------------------------------------------------------
package qpac_pkg;

	localparam int MAX_ROUNDS = 4;

	// register indexes on the configuration port
	localparam logic [2:0] REG_KEY_LOW        = 3'd0;
	localparam logic [2:0] REG_KEY_HIGH       = 3'd1;
	localparam logic [2:0] REG_ROUND_COUNT    = 3'd2;
	localparam logic [2:0] REG_VA_SIZE_OFFSET = 3'd3;
	localparam logic [2:0] REG_TBI_LOW_HALF   = 3'd4;
	localparam logic [2:0] REG_TBI_HIGH_HALF  = 3'd5;
	localparam logic [2:0] REG_PAUTH2_MODE    = 3'd6;

	// operation codes carried in tuser
	localparam logic [1:0] KIND_ADD_PAC = 2'd0;
	localparam logic [1:0] KIND_STRIP   = 2'd1;
	localparam logic [1:0] KIND_RAW     = 2'd2;

	localparam logic [2:0] ROUND_COUNT_RESET = 3'd4;
	localparam logic [5:0] VA_OFFSET_RESET   = 6'd16;
	localparam logic [5:0] VA_OFFSET_MIN     = 6'd12;
	localparam logic [5:0] VA_OFFSET_MAX     = 6'd39;

	localparam logic [63:0] REFLECT_CONST = 64'hC0AC29B7C97C50DD;

	typedef struct packed {
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [2:0]  round_count;
		logic [5:0]  va_size_offset;
		logic        tbi_low_half;
		logic        tbi_high_half;
		logic        pauth2_mode;
	} cfg_t;

	localparam logic [3:0] SBOX_FWD [16] = '{4'hb, 4'h6, 4'h8, 4'hf, 4'hc, 4'h0, 4'h9, 4'he,
		4'h3, 4'h7, 4'h4, 4'h5, 4'hd, 4'h2, 4'h1, 4'ha};
	localparam logic [3:0] SBOX_INV [16] = '{4'h5, 4'he, 4'hd, 4'h8, 4'ha, 4'hb, 4'h1, 4'h9,
		4'h2, 4'h6, 4'hf, 4'h0, 4'h4, 4'hc, 4'h7, 4'h3};
	localparam logic [3:0] PERM_FWD [16] = '{4'd13, 4'd6, 4'd11, 4'd0, 4'd7, 4'd12, 4'd1,
		4'd10, 4'd8, 4'd3, 4'd14, 4'd5, 4'd2, 4'd9, 4'd4, 4'd15};
	localparam logic [3:0] PERM_INV [16] = '{4'd3, 4'd6, 4'd12, 4'd9, 4'd14, 4'd11, 4'd1,
		4'd4, 4'd8, 4'd13, 4'd7, 4'd2, 4'd5, 4'd0, 4'd10, 4'd15};
	localparam logic [3:0] TW_SRC_FWD [16] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd2, 4'd3,
		4'd8, 4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd1, 4'd10, 4'd9};
	localparam logic [15:0] TW_ROT_FWD = 16'b1101_1000_1001_0100;
	localparam logic [3:0] TW_SRC_INV [16] = '{4'd12, 4'd13, 4'd5, 4'd6, 4'd0, 4'd1, 4'd2,
		4'd3, 4'd7, 4'd15, 4'd14, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11};
	localparam logic [15:0] TW_ROT_INV = 16'b1000_1111_0100_0001;

	function automatic logic [63:0] round_const(input logic [2:0] idx);
		logic [63:0] rc;
		case (idx)
			3'd1: rc = 64'h13198A2E03707344;
			3'd2: rc = 64'hA4093822299F31D0;
			3'd3: rc = 64'h082EFA98EC4E6C89;
			3'd4: rc = 64'h452821E638D01377;
			default: rc = 64'h0;
		endcase
		return rc;
	endfunction

	function automatic logic [63:0] sub_fwd(input logic [63:0] v);
		logic [63:0] o;
		for (int c = 0; c < 16; c++) o[c*4 +: 4] = SBOX_FWD[v[c*4 +: 4]];
		return o;
	endfunction

	function automatic logic [63:0] sub_inv(input logic [63:0] v);
		logic [63:0] o;
		for (int c = 0; c < 16; c++) o[c*4 +: 4] = SBOX_INV[v[c*4 +: 4]];
		return o;
	endfunction

	function automatic logic [63:0] perm_fwd(input logic [63:0] v);
		logic [63:0] o;
		for (int c = 0; c < 16; c++) o[c*4 +: 4] = v[PERM_FWD[c]*4 +: 4];
		return o;
	endfunction

	function automatic logic [63:0] perm_inv(input logic [63:0] v);
		logic [63:0] o;
		for (int c = 0; c < 16; c++) o[c*4 +: 4] = v[PERM_INV[c]*4 +: 4];
		return o;
	endfunction

	function automatic logic [3:0] rot1(input logic [3:0] x);
		return {x[2:0], x[3]};
	endfunction

	function automatic logic [3:0] rot2(input logic [3:0] x);
		return {x[1:0], x[3:2]};
	endfunction

	function automatic logic [63:0] mix_columns(input logic [63:0] v);
		logic [63:0] o;
		logic [3:0]  a, b, c, d;
		for (int col = 0; col < 4; col++) begin
			a = v[col*4 +: 4];
			b = v[(col+4)*4 +: 4];
			c = v[(col+8)*4 +: 4];
			d = v[(col+12)*4 +: 4];
			o[(col+12)*4 +: 4] = rot1(c) ^ rot2(b) ^ rot1(a);
			o[(col+8)*4 +: 4]  = rot1(d) ^ rot1(b) ^ rot2(a);
			o[(col+4)*4 +: 4]  = rot2(d) ^ rot1(c) ^ rot1(a);
			o[col*4 +: 4]      = rot1(d) ^ rot2(c) ^ rot1(b);
		end
		return o;
	endfunction

	function automatic logic [63:0] tweak_fwd(input logic [63:0] v);
		logic [63:0] o;
		logic [3:0]  x;
		for (int c = 0; c < 16; c++) begin
			x = v[TW_SRC_FWD[c]*4 +: 4];
			o[c*4 +: 4] = TW_ROT_FWD[c] ? {x[0] ^ x[1], x[3:1]} : x;
		end
		return o;
	endfunction

	function automatic logic [63:0] tweak_inv(input logic [63:0] v);
		logic [63:0] o;
		logic [3:0]  x;
		for (int c = 0; c < 16; c++) begin
			x = v[TW_SRC_INV[c]*4 +: 4];
			o[c*4 +: 4] = TW_ROT_INV[c] ? {x[2:0], x[0] ^ x[3]} : x;
		end
		return o;
	endfunction

endpackage

### sv/qpac_cfg_regs.sv
// ----------------------------------------------------------------------------
// qpac_cfg_regs
// Configuration register file: key halves, round count, address size offset,
// top byte ignore per half and the PAuth2 mode bit.
// ----------------------------------------------------------------------------
module qpac_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	output qpac_pkg::cfg_t     cfg
);

	qpac_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_low        <= '0;
			cfg_q.key_high       <= '0;
			cfg_q.round_count    <= qpac_pkg::ROUND_COUNT_RESET;
			cfg_q.va_size_offset <= qpac_pkg::VA_OFFSET_RESET;
			cfg_q.tbi_low_half   <= 1'b0;
			cfg_q.tbi_high_half  <= 1'b0;
			cfg_q.pauth2_mode    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qpac_pkg::REG_KEY_LOW:        cfg_q.key_low        <= cfg_wdata;
				qpac_pkg::REG_KEY_HIGH:       cfg_q.key_high       <= cfg_wdata;
				qpac_pkg::REG_ROUND_COUNT:    cfg_q.round_count    <= cfg_wdata[2:0];
				qpac_pkg::REG_VA_SIZE_OFFSET: cfg_q.va_size_offset <= cfg_wdata[5:0];
				qpac_pkg::REG_TBI_LOW_HALF:   cfg_q.tbi_low_half   <= cfg_wdata[0];
				qpac_pkg::REG_TBI_HIGH_HALF:  cfg_q.tbi_high_half  <= cfg_wdata[0];
				qpac_pkg::REG_PAUTH2_MODE:    cfg_q.pauth2_mode    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/qpac_cipher.sv
// ----------------------------------------------------------------------------
// qpac_cipher
// One combinational pass of the 64-bit tweakable block cipher: forward
// rounds, central reflector, backward rounds, with a configurable count.
// ----------------------------------------------------------------------------
module qpac_cipher (
	input  logic [63:0] data,
	input  logic [63:0] tweak,
	input  logic [63:0] k0,
	input  logic [63:0] k1,
	input  logic [2:0]  round_count,
	output logic [63:0] result
);

	logic [2:0]  n;
	logic [63:0] k0p;
	logic [63:0] s;
	logic [63:0] t;

	// counts above the maximum act as the maximum
	assign n   = (round_count > 3'(qpac_pkg::MAX_ROUNDS)) ? 3'(qpac_pkg::MAX_ROUNDS)
		: round_count;
	assign k0p = {k0[0], k0[63:2], k0[1] ^ k0[63]};

	always_comb begin
		t = tweak;
		s = data ^ k0;
		for (int r = 0; r <= qpac_pkg::MAX_ROUNDS; r++) begin
			if (3'(r) <= n) begin
				s = s ^ k1 ^ t ^ qpac_pkg::round_const(3'(r));
				if (r > 0) s = qpac_pkg::mix_columns(qpac_pkg::perm_fwd(s));
				s = qpac_pkg::sub_fwd(s);
				t = qpac_pkg::tweak_fwd(t);
			end
		end
		// reflector
		s = s ^ k0p ^ t;
		s = qpac_pkg::sub_fwd(qpac_pkg::mix_columns(qpac_pkg::perm_fwd(s)));
		s = qpac_pkg::mix_columns(qpac_pkg::perm_fwd(s)) ^ k1;
		s = qpac_pkg::sub_inv(qpac_pkg::perm_inv(s));
		s = qpac_pkg::perm_inv(qpac_pkg::mix_columns(s));
		s = s ^ k0 ^ t;
		for (int r = 0; r <= qpac_pkg::MAX_ROUNDS; r++) begin
			if (3'(r) <= n) begin
				s = qpac_pkg::sub_inv(s);
				if (3'(r) < n) s = qpac_pkg::perm_inv(qpac_pkg::mix_columns(s));
				t = qpac_pkg::tweak_inv(t);
				s = s ^ qpac_pkg::round_const(n - 3'(r)) ^ k1 ^ t ^ qpac_pkg::REFLECT_CONST;
			end
		end
		result = s ^ k0p;
	end

endmodule

### sv/qpac_format.sv
// ----------------------------------------------------------------------------
// qpac_format
// Pointer formatting around the cipher: canonical extension, PAC insertion
// with top byte ignore, strip, and raw compute selection.
// ----------------------------------------------------------------------------
module qpac_format (
	input  qpac_pkg::cfg_t cfg,
	input  logic [1:0]     kind,
	input  logic [63:0]    pointer,
	input  logic [63:0]    modifier,
	output logic [63:0]    out_value
);

	logic [5:0]  size_off;
	logic [5:0]  bot;
	logic        tbi;
	logic        ext;
	logic [63:0] field_m;
	logic [63:0] low_m;
	logic [63:0] pac_keep;
	logic [63:0] ptr_keep;
	logic        non_canon;
	logic [63:0] cipher_in;
	logic [63:0] cipher_out;
	logic [63:0] pac;
	logic [63:0] signed_ptr;
	logic [63:0] stripped;

	always_comb begin
		if (cfg.va_size_offset < qpac_pkg::VA_OFFSET_MIN) size_off = qpac_pkg::VA_OFFSET_MIN;
		else if (cfg.va_size_offset > qpac_pkg::VA_OFFSET_MAX)
			size_off = qpac_pkg::VA_OFFSET_MAX;
		else size_off = cfg.va_size_offset;
	end

	assign bot = 6'd0 - size_off;
	assign tbi = pointer[55] ? cfg.tbi_high_half : cfg.tbi_low_half;
	assign ext = tbi ? pointer[55] : pointer[63];

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			low_m[i]    = (7'(i) < {1'b0, bot});
			field_m[i]  = !low_m[i] && (!tbi || i < 56);
			pac_keep[i] = !low_m[i] && (i != 55) && (!tbi || i < 55);
			ptr_keep[i] = low_m[i] || (tbi && i >= 56);
		end
	end

	// field neither all zeros nor all ones
	assign non_canon = |(pointer & field_m) && |(~pointer & field_m);

	assign cipher_in = (kind == qpac_pkg::KIND_RAW) ? pointer
		: ((pointer & ~field_m) | ({64{ext}} & field_m));

	qpac_cipher u_cipher (
		.data        (cipher_in),
		.tweak       (modifier),
		.k0          (cfg.key_high),
		.k1          (cfg.key_low),
		.round_count (cfg.round_count),
		.result      (cipher_out)
	);

	always_comb begin
		pac = cipher_out;
		if (cfg.pauth2_mode) pac = pac ^ pointer;
		else if (non_canon) begin
			if (tbi) pac[54] = ~pac[54];
			else pac[62] = ~pac[62];
		end
		signed_ptr     = (pac & pac_keep) | (pointer & ptr_keep);
		signed_ptr[55] = ext;
	end

	assign stripped = pointer[55] ? (pointer | field_m) : (pointer & ~field_m);

	always_comb begin
		case (kind)
			qpac_pkg::KIND_ADD_PAC: out_value = signed_ptr;
			qpac_pkg::KIND_STRIP:   out_value = stripped;
			qpac_pkg::KIND_RAW:     out_value = cipher_out;
			default:                out_value = '0;
		endcase
	end

endmodule

### sv/qarma_pointer_auth_code_unit.sv
// ----------------------------------------------------------------------------
// qarma_pointer_auth_code_unit
// Pointer authentication code unit: add PAC, strip PAC and raw cipher compute
// on a stream of items, configured through a plain register write port.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless the output side stalls, and returns one
// result item for each, in order. An accepted item sits in the input register
// while the whole cipher pass and pointer formatting run in combinational logic,
// and its result is taken into the output register when stage one advances; it
// leaves from there on the output stream. The single cipher pass between those
// two registers sets the clock period. A result that waits on m_tready holds the
// output register; the input register still takes one more item behind it.
// Configuration must be written only while no item is in flight; the block
// itself does not enforce this.
module qarma_pointer_auth_code_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // pointer[63:0], modifier[127:64]
	input  logic [1:0]   s_tuser,   // kind[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // out_value[63:0]
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_wdata
);

	qpac_pkg::cfg_t cfg;

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [63:0] pointer_s1;
	logic [63:0] modifier_s1;
	logic        advance;
	logic [63:0] result;
	logic [63:0] out_value_q;
	logic        out_valid_q;

	qpac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage one moves on when the output register is free or being emptied
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1     <= s_tuser;
			pointer_s1  <= s_tdata[63:0];
			modifier_s1 <= s_tdata[127:64];
		end
	end

	qpac_format u_format (
		.cfg       (cfg),
		.kind      (kind_s1),
		.pointer   (pointer_s1),
		.modifier  (modifier_s1),
		.out_value (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_value_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;

	// a stalled item in stage one keeps its payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pointer_s1) && $stable(kind_s1)))
		else $error("stage one item changed while stalled");

	// an item leaving stage one lands in the output register
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_tvalid)
		else $error("item lost between stage one and output");

	// strip never changes the selector bit
	a_strip_bit55: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && kind_s1 == qpac_pkg::KIND_STRIP)
		|=> (m_tdata[55] == $past(pointer_s1[55])))
		else $error("strip altered pointer bit 55");

	// the unused kind code gives a zero result
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && kind_s1 != qpac_pkg::KIND_ADD_PAC
			&& kind_s1 != qpac_pkg::KIND_STRIP && kind_s1 != qpac_pkg::KIND_RAW)
		|=> (m_tdata == 64'h0))
		else $error("unused kind gave a nonzero result");

endmodule

### dv/qarma_pointer_auth_code_unit_checker.sv
// ----------------------------------------------------------------------------
// qarma_pointer_auth_code_unit_checker
// Watches the item streams and the register port of the pointer
// authentication unit. Predicts each result with its own QARMA-64 model and
// compares the results in order.
// ----------------------------------------------------------------------------
module qarma_pointer_auth_code_unit_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,   // pointer[63:0], modifier[127:64]
	input  logic [1:0]   s_tuser,   // kind[1:0]
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,   // out_value[63:0]
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	output int           mismatch_count,
	output int           results_seen,
	output int           in_flight
);

	// nibble tables, entry i in bits [4*i +: 4]
	localparam logic [63:0] SB_FWD    = 64'hA12D_5473_E90C_F86B;
	localparam logic [63:0] SB_INV    = 64'h37C4_0F62_91BA_8DE5;
	localparam logic [63:0] SHUF_FWD  = 64'hF492_5E38_A1C7_0B6D;
	localparam logic [63:0] SHUF_INV  = 64'hFA05_27D8_41BE_9C63;
	localparam logic [63:0] TWK_FWD   = 64'h9A10_FEDC_832B_7654;
	localparam logic [63:0] TWK_INV   = 64'hBA98_4EF7_3210_65DC;
	localparam logic [15:0] TWK_LFSR_FWD = 16'b1101_1000_1001_0100;
	localparam logic [15:0] TWK_LFSR_INV = 16'b1000_1111_0100_0001;
	localparam logic [63:0] REFLECTOR = 64'hC0AC_29B7_C97C_50DD;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] ptr;
		logic [63:0] modifier;
		logic [63:0] value;
	} pac_result_t;

	pac_result_t    predicted_out_q [$];
	qpac_pkg::cfg_t regs;

	function automatic logic [63:0] round_key_const(input int r);
		logic [63:0] rc;
		case (r)
			1: rc = 64'h1319_8A2E_0370_7344;
			2: rc = 64'hA409_3822_299F_31D0;
			3: rc = 64'h082E_FA98_EC4E_6C89;
			4: rc = 64'h4528_21E6_38D0_1377;
			default: rc = 64'h0;
		endcase
		return rc;
	endfunction

	function automatic logic [63:0] sbox_apply(input logic [63:0] v, input logic [63:0] tbl);
		logic [63:0] o;
		int          idx;
		for (int c = 0; c < 16; c++) begin
			idx = int'(v[c*4 +: 4]);
			o[c*4 +: 4] = tbl[idx*4 +: 4];
		end
		return o;
	endfunction

	function automatic logic [63:0] shuffle(input logic [63:0] v, input logic [63:0] src);
		logic [63:0] o;
		int          idx;
		for (int c = 0; c < 16; c++) begin
			idx = int'(src[c*4 +: 4]);
			o[c*4 +: 4] = v[idx*4 +: 4];
		end
		return o;
	endfunction

	function automatic logic [3:0] rot_left4(input logic [3:0] x, input int n);
		logic [7:0] d;
		d = {x, x} << n;
		return d[7:4];
	endfunction

	function automatic logic [63:0] mix_cols(input logic [63:0] v);
		logic [63:0] o;
		logic [3:0]  a, b, c, d;
		for (int col = 0; col < 4; col++) begin
			a = v[col*4 +: 4];
			b = v[(col+4)*4 +: 4];
			c = v[(col+8)*4 +: 4];
			d = v[(col+12)*4 +: 4];
			o[col*4 +: 4]      = rot_left4(d, 1) ^ rot_left4(c, 2) ^ rot_left4(b, 1);
			o[(col+4)*4 +: 4]  = rot_left4(d, 2) ^ rot_left4(c, 1) ^ rot_left4(a, 1);
			o[(col+8)*4 +: 4]  = rot_left4(d, 1) ^ rot_left4(b, 1) ^ rot_left4(a, 2);
			o[(col+12)*4 +: 4] = rot_left4(c, 1) ^ rot_left4(b, 2) ^ rot_left4(a, 1);
		end
		return o;
	endfunction

	function automatic logic [63:0] tweak_update(input logic [63:0] v, input logic [63:0] src,
			input logic [15:0] lfsr_sel, input logic fwd);
		logic [63:0] o;
		logic [3:0]  x;
		int          idx;
		for (int c = 0; c < 16; c++) begin
			idx = int'(src[c*4 +: 4]);
			x = v[idx*4 +: 4];
			if (lfsr_sel[c])
				x = fwd ? {x[0] ^ x[1], x[3:1]} : {x[2:0], x[0] ^ x[3]};
			o[c*4 +: 4] = x;
		end
		return o;
	endfunction

	function automatic logic [63:0] qarma_encipher(input logic [63:0] data, tweak,
			input qpac_pkg::cfg_t c);
		logic [63:0] k0, k1, k0p, t, s;
		int          n;
		k0  = c.key_high;
		k1  = c.key_low;
		k0p = {k0[0], k0[63:1]} ^ {63'd0, k0[63]};
		t   = tweak;
		s   = data ^ k0;
		n   = (int'(c.round_count) > qpac_pkg::MAX_ROUNDS) ? qpac_pkg::MAX_ROUNDS
			: int'(c.round_count);
		for (int r = 0; r <= n; r++) begin
			s ^= k1 ^ t ^ round_key_const(r);
			if (r > 0)
				s = mix_cols(shuffle(s, SHUF_FWD));
			s = sbox_apply(s, SB_FWD);
			t = tweak_update(t, TWK_FWD, TWK_LFSR_FWD, 1'b1);
		end
		// reflector
		s ^= k0p ^ t;
		s = sbox_apply(mix_cols(shuffle(s, SHUF_FWD)), SB_FWD);
		s = mix_cols(shuffle(s, SHUF_FWD)) ^ k1;
		s = sbox_apply(shuffle(s, SHUF_INV), SB_INV);
		s = shuffle(mix_cols(s), SHUF_INV);
		s ^= k0 ^ t;
		for (int r = 0; r <= n; r++) begin
			s = sbox_apply(s, SB_INV);
			if (r < n)
				s = shuffle(mix_cols(s), SHUF_INV);
			t = tweak_update(t, TWK_INV, TWK_LFSR_INV, 1'b0);
			s ^= round_key_const(n - r) ^ k1 ^ t ^ REFLECTOR;
		end
		return s ^ k0p;
	endfunction

	function automatic logic [63:0] bit_span(input int lo, input int len);
		logic [63:0] m;
		m = (len >= 64) ? {64{1'b1}} : ((64'd1 << len) - 64'd1);
		return (lo >= 64) ? 64'd0 : (m << lo);
	endfunction

	function automatic int pac_bottom(input qpac_pkg::cfg_t c);
		int off;
		off = int'(c.va_size_offset);
		if (off < int'(qpac_pkg::VA_OFFSET_MIN))
			off = int'(qpac_pkg::VA_OFFSET_MIN);
		if (off > int'(qpac_pkg::VA_OFFSET_MAX))
			off = int'(qpac_pkg::VA_OFFSET_MAX);
		return 64 - off;
	endfunction

	function automatic logic [63:0] sign_pointer(input logic [63:0] ptr, tweak,
			input qpac_pkg::cfg_t c);
		logic        tbi;
		int          bot, top, len;
		logic [63:0] ext, fm, field, pac;
		tbi   = ptr[55] ? c.tbi_high_half : c.tbi_low_half;
		bot   = pac_bottom(c);
		top   = tbi ? 56 : 64;
		len   = top - bot;
		ext   = (tbi ? ptr[55] : ptr[63]) ? {64{1'b1}} : 64'd0;
		fm    = bit_span(bot, len);
		field = (ptr >> bot) & bit_span(0, len);
		pac   = qarma_encipher((ptr & ~fm) | (ext & fm), tweak, c);
		// non-canonical pointer: flag it in the code unless pauth2
		if (field != 64'd0 && field != bit_span(0, len) && !c.pauth2_mode)
			pac ^= 64'd1 << (top - 2);
		if (c.pauth2_mode)
			pac ^= ptr;
		if (tbi) begin
			ptr &= ~bit_span(bot, 56 - bot);
			pac &= bit_span(bot, 55 - bot);
		end else begin
			ptr &= bit_span(0, bot);
			pac &= ~(bit_span(55, 1) | bit_span(0, bot));
		end
		return pac | (ext & bit_span(55, 1)) | ptr;
	endfunction

	function automatic logic [63:0] strip_pointer(input logic [63:0] ptr,
			input qpac_pkg::cfg_t c);
		logic        tbi;
		int          bot;
		logic [63:0] m;
		tbi = ptr[55] ? c.tbi_high_half : c.tbi_low_half;
		bot = pac_bottom(c);
		m   = bit_span(bot, (tbi ? 56 : 64) - bot);
		return ptr[55] ? (ptr | m) : (ptr & ~m);
	endfunction

	function automatic logic [63:0] predict_out_value(input logic [1:0] kind,
			input logic [63:0] ptr, modifier, input qpac_pkg::cfg_t c);
		logic [63:0] v;
		case (kind)
			qpac_pkg::KIND_ADD_PAC: v = sign_pointer(ptr, modifier, c);
			qpac_pkg::KIND_STRIP:   v = strip_pointer(ptr, c);
			qpac_pkg::KIND_RAW:     v = qarma_encipher(ptr, modifier, c);
			default:                v = 64'd0;
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pac_result_t exp_item;
		if (!arst_n) begin
			regs.key_low        <= 64'd0;
			regs.key_high       <= 64'd0;
			regs.round_count    <= qpac_pkg::ROUND_COUNT_RESET;
			regs.va_size_offset <= qpac_pkg::VA_OFFSET_RESET;
			regs.tbi_low_half   <= 1'b0;
			regs.tbi_high_half  <= 1'b0;
			regs.pauth2_mode    <= 1'b0;
			predicted_out_q.delete();
			mismatch_count <= 0;
			results_seen   <= 0;
			in_flight      <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (predicted_out_q.size() == 0) begin
					$display("%0t: result item %h with nothing expected", $time, m_tdata);
					mismatch_count <= mismatch_count + 1;
				end else begin
					exp_item = predicted_out_q.pop_front();
					if (m_tdata !== exp_item.value) begin
						$display("%0t: out_value mismatch kind %0d ptr %h mod %h: expected %h got %h",
							$time, exp_item.kind, exp_item.ptr, exp_item.modifier,
							exp_item.value, m_tdata);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				exp_item.kind     = s_tuser;
				exp_item.ptr      = s_tdata[63:0];
				exp_item.modifier = s_tdata[127:64];
				exp_item.value    = predict_out_value(s_tuser, s_tdata[63:0], s_tdata[127:64],
					regs);
				predicted_out_q.push_back(exp_item);
			end
			if (cfg_we) begin
				case (cfg_index)
					qpac_pkg::REG_KEY_LOW:        regs.key_low        <= cfg_wdata;
					qpac_pkg::REG_KEY_HIGH:       regs.key_high       <= cfg_wdata;
					qpac_pkg::REG_ROUND_COUNT:    regs.round_count    <= cfg_wdata[2:0];
					qpac_pkg::REG_VA_SIZE_OFFSET: regs.va_size_offset <= cfg_wdata[5:0];
					qpac_pkg::REG_TBI_LOW_HALF:   regs.tbi_low_half   <= cfg_wdata[0];
					qpac_pkg::REG_TBI_HIGH_HALF:  regs.tbi_high_half  <= cfg_wdata[0];
					qpac_pkg::REG_PAUTH2_MODE:    regs.pauth2_mode    <= cfg_wdata[0];
					default: ;
				endcase
			end
			in_flight <= predicted_out_q.size();
		end
	end

endmodule

### dv/qarma_pointer_auth_code_unit_tb.sv
// ----------------------------------------------------------------------------
// qarma_pointer_auth_code_unit_tb
// Drives directed and random add-PAC, strip, raw cipher and unused-kind items
// through the unit under a series of register settings, with random gaps and
// stalls on both streams, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module qarma_pointer_auth_code_unit_tb;

	localparam logic [2:0] REG_UNUSED  = 3'd7;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE    = 104;
	localparam int NUM_PHASES          = 8;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic [127:0] s_tdata   = '0;
	logic [1:0]   s_tuser   = qpac_pkg::KIND_ADD_PAC;
	logic         m_tready  = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [2:0]   cfg_index = qpac_pkg::REG_KEY_LOW;
	logic [63:0]  cfg_wdata = '0;
	logic         s_tready;
	logic         m_tvalid;
	logic [63:0]  m_tdata;

	int mismatch_count;
	int results_seen;
	int in_flight;
	int items_by_kind [4];
	int burst_left  = 0;
	int sink_left   = 0;
	int sink_pick;
	int phases_run  = 0;

	qarma_pointer_auth_code_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	qarma_pointer_auth_code_unit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.results_seen   (results_seen),
		.in_flight      (in_flight)
	);

	always #5 clk = ~clk;

	// result side pacing: runs of ready and stalls, a few of them long
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_pick = $urandom_range(0, 99);
			if (sink_pick < 55) begin
				m_tready <= 1'b1;
				sink_left = $urandom_range(1, 8);
			end else if (sink_pick < 85) begin
				m_tready <= 1'b0;
				sink_left = $urandom_range(1, 3);
			end else if (sink_pick < 92) begin
				m_tready <= 1'b0;
				sink_left = $urandom_range(10, 40);
			end else begin
				m_tready <= 1'b1;
				sink_left = $urandom_range(30, 80);
			end
		end else begin
			sink_left--;
		end
	end

	function automatic int pick_gap();
		int p;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 4) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (p < 55)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input logic [1:0] kind, input logic [63:0] ptr, modifier);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {modifier, ptr};
		do @(posedge clk); while (!s_tready);
		items_by_kind[kind]++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// narrow registers get junk in the unused upper bits
	task automatic apply_settings(input qpac_pkg::cfg_t c);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(qpac_pkg::REG_KEY_LOW, c.key_low);
		write_reg(qpac_pkg::REG_KEY_HIGH, c.key_high);
		write_reg(qpac_pkg::REG_ROUND_COUNT, {junk[63:3], c.round_count});
		write_reg(qpac_pkg::REG_VA_SIZE_OFFSET, {junk[63:6], c.va_size_offset});
		write_reg(qpac_pkg::REG_TBI_LOW_HALF, {junk[63:1], c.tbi_low_half});
		write_reg(qpac_pkg::REG_TBI_HIGH_HALF, {junk[62:0], c.tbi_high_half});
		write_reg(qpac_pkg::REG_PAUTH2_MODE, {junk[61:0], junk[63], c.pauth2_mode});
		write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
		phases_run++;
	endtask

	function automatic qpac_pkg::cfg_t phase_settings(input int phase);
		qpac_pkg::cfg_t c;
		c.key_low        = {$urandom, $urandom};
		c.key_high       = {$urandom, $urandom};
		c.round_count    = 3'($urandom_range(0, 7));
		c.va_size_offset = 6'($urandom_range(12, 39));
		c.tbi_low_half   = 1'($urandom_range(0, 1));
		c.tbi_high_half  = 1'($urandom_range(0, 1));
		c.pauth2_mode    = 1'($urandom_range(0, 1));
		case (phase)
			0: begin
				c.round_count = 3'd4;  c.va_size_offset = 6'd16;
				c.tbi_low_half = 1'b0; c.tbi_high_half = 1'b0; c.pauth2_mode = 1'b0;
			end
			1: begin
				c.key_low = '1; c.key_high = '1;
				c.round_count = 3'd0;  c.va_size_offset = 6'd12;
				c.tbi_low_half = 1'b1; c.tbi_high_half = 1'b0; c.pauth2_mode = 1'b0;
			end
			2: begin
				c.key_low = '0;
				c.round_count = 3'd7;  c.va_size_offset = 6'd39;
				c.tbi_low_half = 1'b0; c.tbi_high_half = 1'b1; c.pauth2_mode = 1'b1;
			end
			3: begin
				c.round_count = 3'd1;  c.va_size_offset = 6'd0;
				c.tbi_low_half = 1'b1; c.tbi_high_half = 1'b1; c.pauth2_mode = 1'b0;
			end
			4: begin
				c.round_count = 3'd2;  c.va_size_offset = 6'd63;
				c.tbi_low_half = 1'b1; c.tbi_high_half = 1'b1; c.pauth2_mode = 1'b1;
			end
			5: c.round_count = 3'd3;
			6: begin
				c.round_count    = 3'($urandom_range(5, 7));
				c.va_size_offset = 6'($urandom_range(0, 63));
			end
			default: ;
		endcase
		return c;
	endfunction

	// mostly pointers sign-extended above some bit, often right at the code field
	function automatic logic [63:0] make_pointer(input qpac_pkg::cfg_t c);
		logic [63:0] raw;
		int          p, split, off, b;
		raw = {$urandom, $urandom};
		p = $urandom_range(0, 99);
		if (p < 15)
			return raw;
		off = int'(c.va_size_offset);
		if (off < 12)
			off = 12;
		if (off > 39)
			off = 39;
		split = ($urandom_range(0, 1) == 1) ? 64 - off : $urandom_range(24, 56);
		if (raw[split-1])
			raw |= ~64'd0 << split;
		else
			raw &= ~(~64'd0 << split);
		if (p < 40)
			raw[63:56] = 8'($urandom);
		if (p >= 85) begin
			b = $urandom_range(25, 63);
			raw[b] = ~raw[b];
		end
		return raw;
	endfunction

	task automatic send_random_item(input qpac_pkg::cfg_t c);
		logic [1:0]  kind;
		logic [63:0] modifier;
		int          p;
		p = $urandom_range(0, 99);
		if (p < 50)
			kind = qpac_pkg::KIND_ADD_PAC;
		else if (p < 72)
			kind = qpac_pkg::KIND_STRIP;
		else if (p < 96)
			kind = qpac_pkg::KIND_RAW;
		else
			kind = KIND_UNUSED;
		p = $urandom_range(0, 99);
		if (p < 5)
			modifier = '0;
		else if (p < 10)
			modifier = '1;
		else
			modifier = {$urandom, $urandom};
		send_item(kind, make_pointer(c), modifier);
	endtask

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		qpac_pkg::cfg_t settings;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items under the reset settings
		send_item(qpac_pkg::KIND_ADD_PAC, 64'h0, 64'h0);
		send_item(qpac_pkg::KIND_ADD_PAC, '1, '1);
		send_item(qpac_pkg::KIND_ADD_PAC, 64'h0000_7FFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF);
		send_item(qpac_pkg::KIND_ADD_PAC, 64'hFFFF_8000_0000_0000, {$urandom, $urandom});
		// non-canonical in the low half, in the high half, and sign bit alone
		send_item(qpac_pkg::KIND_ADD_PAC, 64'h0001_0000_0000_1000, {$urandom, $urandom});
		send_item(qpac_pkg::KIND_ADD_PAC, 64'h7F80_0000_0000_0000, {$urandom, $urandom});
		send_item(qpac_pkg::KIND_ADD_PAC, 64'h8000_0000_0000_0000, '1);
		send_item(qpac_pkg::KIND_STRIP, 64'h1234_5678_9ABC_DEF0, {$urandom, $urandom});
		send_item(qpac_pkg::KIND_STRIP, 64'hFFA5_0000_1111_2222, '0);
		send_item(qpac_pkg::KIND_STRIP, 64'h0, '1);
		send_item(qpac_pkg::KIND_STRIP, '1, '0);
		send_item(qpac_pkg::KIND_RAW, 64'h0, 64'h0);
		send_item(qpac_pkg::KIND_RAW, '1, '1);
		send_item(qpac_pkg::KIND_RAW, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		send_item(qpac_pkg::KIND_RAW, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(KIND_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(KIND_UNUSED, '1, '1);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			settings = phase_settings(phase);
			apply_settings(settings);
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				send_random_item(settings);
		end
		wait_drained();
		repeat (10) @(posedge clk);

		$display("covered %0d add, %0d strip, %0d raw and %0d unused-kind items",
			items_by_kind[0], items_by_kind[1], items_by_kind[2], items_by_kind[3]);
		$display("%0d register settings written, %0d result items compared",
			phases_run, results_seen);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
